FILE: sv/stuffed_frame_decoder_unit_macros.svh
// Assertion macros shared by the stuffed frame decoder modules.
`ifndef STUFFED_FRAME_DECODER_UNIT_MACROS_SVH
`define STUFFED_FRAME_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sfd_pkg.sv
// Shared types and constants of the stuffed frame decoder.
package sfd_pkg;

    localparam int PAYLOAD_BYTES = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_DATA = 8'h00;
    localparam logic [7:0] BYTE_SOF  = 8'h01;
    localparam logic [7:0] BYTE_EOF  = 8'h02;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_LONG  = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_ESC   = 3'd4;

    typedef logic [1:0] t_op_kind;
    localparam t_op_kind OP_OPEN  = 2'd0;
    localparam t_op_kind OP_PUSH  = 2'd1;
    localparam t_op_kind OP_CLOSE = 2'd2;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        mode;
        logic signed [7:0] lr;
        logic signed [7:0] fb;
    } t_res;

endpackage

FILE: sv/sfd_fifo.sv
// Small register-based first-in first-out queue.
module sfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/sfd_front.sv
// Front end: finds header and trailer pairs and classifies each byte.
`include "stuffed_frame_decoder_unit_macros.svh"

module sfd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    output logic         o_op_push,
    output sfd_pkg::t_op o_op
);

    logic r_prev_ff, n_prev_ff;
    logic r_in_frame, n_in_frame;
    logic is_sof, is_eof;

    assign is_sof = r_prev_ff && (i_byte == sfd_pkg::BYTE_SOF);
    assign is_eof = r_prev_ff && (i_byte == sfd_pkg::BYTE_EOF);

    always_comb begin
        n_prev_ff   = r_prev_ff;
        n_in_frame  = r_in_frame;
        o_op_push   = 1'b0;
        o_op.kind   = sfd_pkg::OP_PUSH;
        o_op.data   = i_byte;
        if (i_accept) begin
            n_prev_ff = (i_byte == sfd_pkg::BYTE_FF);
            priority if (is_sof) begin
                n_in_frame = 1'b1;
                o_op_push  = 1'b1;
                o_op.kind  = sfd_pkg::OP_OPEN;
            end else if (is_eof) begin
                // A trailer outside a frame is dropped here.
                if (r_in_frame) begin
                    n_in_frame = 1'b0;
                    o_op_push  = 1'b1;
                    o_op.kind  = sfd_pkg::OP_CLOSE;
                end
            end else if (r_in_frame) begin
                o_op_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ff  <= 1'b0;
            r_in_frame <= 1'b0;
        end else begin
            r_prev_ff  <= n_prev_ff;
            r_in_frame <= n_in_frame;
        end
    end

    `SFD_ASSERT_IMPLY(a_op_in_frame, i_clk, i_rst_n, o_op_push && (o_op.kind != sfd_pkg::OP_OPEN), r_in_frame, "body or trailer item issued outside a frame")
    `SFD_ASSERT_NEXT(a_eof_leaves_frame, i_clk, i_rst_n, i_accept && is_eof, !r_in_frame, "frame still open after a trailer")

endmodule

FILE: sv/sfd_back.sv
// Back end: checksum, unstuffing, length checks and held command values.
`include "stuffed_frame_decoder_unit_macros.svh"

module sfd_back #(
    parameter int PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  sfd_pkg::t_op  i_op,
    output logic          o_op_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output sfd_pkg::t_res o_res
);

    localparam int CW     = $clog2(PAYLOAD_BYTES + 2);
    localparam int LR_IDX = (PAYLOAD_BYTES > 1) ? 1 : 0;
    localparam int FB_IDX = (PAYLOAD_BYTES > 2) ? 2 : 0;
    localparam logic [CW-1:0] P_CNT = CW'(PAYLOAD_BYTES);
    localparam logic [CW-1:0] P_MAX = CW'(PAYLOAD_BYTES + 1);

    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_pend0, n_pend0;
    logic [7:0]    r_pend1, n_pend1;
    logic [1:0]    r_pcount, n_pcount;
    logic [CW-1:0] r_dcount, n_dcount;
    logic [7:0]    r_dbytes [PAYLOAD_BYTES];
    logic          r_esc_err, n_esc_err;
    logic          r_esc_open, n_esc_open;
    logic [7:0]    r_mode, n_mode;
    logic [7:0]    r_lr, n_lr;
    logic [7:0]    r_fb, n_fb;

    logic          store_en;
    logic [7:0]    store_val;
    logic [CW-1:0] close_cnt;
    logic          close_err;
    logic [2:0]    status;

    function automatic logic [CW-1:0] f_count_up(input logic [CW-1:0] cnt);
        return (cnt <= P_CNT) ? cnt + CW'(1) : cnt;
    endfunction

    assign o_op_pop   = i_op_valid && !((i_op.kind == sfd_pkg::OP_CLOSE) && i_res_full);
    assign o_res_push = o_op_pop && (i_op.kind == sfd_pkg::OP_CLOSE);

    always_comb begin
        n_sum      = r_sum;
        n_pend0    = r_pend0;
        n_pend1    = r_pend1;
        n_pcount   = r_pcount;
        n_dcount   = r_dcount;
        n_esc_err  = r_esc_err;
        n_esc_open = r_esc_open;
        n_mode     = r_mode;
        n_lr       = r_lr;
        n_fb       = r_fb;
        store_en   = 1'b0;
        store_val  = r_pend0;
        close_cnt  = r_dcount;
        close_err  = r_esc_err;
        status     = sfd_pkg::ST_OK;

        if (o_op_pop) begin
            unique case (i_op.kind)
                sfd_pkg::OP_OPEN: begin
                    n_sum      = '0;
                    n_pend0    = '0;
                    n_pend1    = '0;
                    n_pcount   = '0;
                    n_dcount   = '0;
                    n_esc_err  = 1'b0;
                    n_esc_open = 1'b0;
                end
                sfd_pkg::OP_PUSH: begin
                    if (r_pcount == 2'd2) begin
                        // The oldest pending byte is now known to be body.
                        n_sum   = r_sum + r_pend0;
                        n_pend0 = r_pend1;
                        n_pend1 = i_op.data;
                        if (r_esc_open) begin
                            n_esc_open = 1'b0;
                            if (r_dcount >= P_CNT) begin
                                n_dcount = f_count_up(r_dcount);
                            end else if (r_pend0 == sfd_pkg::BYTE_DATA) begin
                                store_en  = 1'b1;
                                store_val = sfd_pkg::BYTE_FF;
                                n_dcount  = f_count_up(r_dcount);
                            end else begin
                                n_esc_err = 1'b1;
                                n_dcount  = f_count_up(r_dcount);
                            end
                        end else if (r_pend0 == sfd_pkg::BYTE_FF) begin
                            n_esc_open = 1'b1;
                        end else begin
                            store_en = 1'b1;
                            n_dcount = f_count_up(r_dcount);
                        end
                    end else if (r_pcount == 2'd1) begin
                        n_pend1  = i_op.data;
                        n_pcount = 2'd2;
                    end else begin
                        n_pend0  = i_op.data;
                        n_pcount = 2'd1;
                    end
                end
                sfd_pkg::OP_CLOSE: begin
                    // A dangling escape is an error, or one byte too many.
                    if (r_esc_open) begin
                        if (r_dcount >= P_CNT) begin
                            close_cnt = f_count_up(r_dcount);
                        end else begin
                            close_err = 1'b1;
                        end
                    end
                    priority if (r_pcount != 2'd2) begin
                        status = sfd_pkg::ST_SHORT;
                    end else if (r_sum != r_pend0) begin
                        status = sfd_pkg::ST_SUM;
                    end else if (close_err) begin
                        status = sfd_pkg::ST_ESC;
                    end else if (close_cnt > P_CNT) begin
                        status = sfd_pkg::ST_LONG;
                    end else if (close_cnt < P_CNT) begin
                        status = sfd_pkg::ST_SHORT;
                    end else begin
                        status = sfd_pkg::ST_OK;
                        n_mode = r_dbytes[0];
                        if (PAYLOAD_BYTES > 1) begin
                            n_lr = r_dbytes[LR_IDX];
                        end
                        if (PAYLOAD_BYTES > 2) begin
                            n_fb = r_dbytes[FB_IDX];
                        end
                    end
                    n_sum      = '0;
                    n_pend0    = '0;
                    n_pend1    = '0;
                    n_pcount   = '0;
                    n_dcount   = '0;
                    n_esc_err  = 1'b0;
                    n_esc_open = 1'b0;
                end
                default: begin
                end
            endcase
        end

        o_res.status = status;
        o_res.mode   = n_mode;
        o_res.lr     = $signed(n_lr);
        o_res.fb     = $signed(n_fb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_pcount   <= '0;
            r_dcount   <= '0;
            r_esc_err  <= 1'b0;
            r_esc_open <= 1'b0;
            r_mode     <= '0;
            r_lr       <= '0;
            r_fb       <= '0;
        end else begin
            r_sum      <= n_sum;
            r_pcount   <= n_pcount;
            r_dcount   <= n_dcount;
            r_esc_err  <= n_esc_err;
            r_esc_open <= n_esc_open;
            r_mode     <= n_mode;
            r_lr       <= n_lr;
            r_fb       <= n_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend0 <= n_pend0;
        r_pend1 <= n_pend1;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (store_en && (r_dcount == CW'(i))) begin
                r_dbytes[i] <= store_val;
            end
        end
    end

    `SFD_ASSERT_IMPLY(a_count_saturates, i_clk, i_rst_n, 1'b1, r_dcount <= P_MAX, "decoded count past its saturation point")
    `SFD_ASSERT_IMPLY(a_escape_after_commit, i_clk, i_rst_n, r_esc_open, r_pcount == 2'd2, "escape open without committed body bytes")
    `SFD_ASSERT_NEXT(a_open_clears, i_clk, i_rst_n, o_op_pop && (i_op.kind == sfd_pkg::OP_OPEN), (r_pcount == 2'd0) && (r_dcount == '0) && !r_esc_open, "header did not clear the frame state")

endmodule

FILE: sv/stuffed_frame_decoder_unit.sv
// Top level of the byte-stuffed command frame decoder.
//
//   Channel   Handshake              Payload
//   input     push / full            i_rx_byte
//   result    empty / pop            o_frame_status, o_mode_value, o_lr_offset, o_fb_offset
//
// The block takes one byte in every clock cycle while full is low. Its pace is set
// by the back end, which executes one queued item per cycle unless it stalls.
// A trailer's status reaches the result ports by way of the item queue and the
// result queue: the accepting edge writes the item into the item queue, and the
// back end executes it from there and writes its status into the result queue.
// Reset is synchronous and leaves both queues empty and the frame counters, flags and held values cleared.
// full rises only when the two-entry internal queue is occupied; the back end
// stalls only when a trailer is at its head and the result queue is full.
module stuffed_frame_decoder_unit #(
    parameter int PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES,
    parameter int QUEUE_DEPTH   = sfd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        o_frame_status,
    output logic [7:0]        o_mode_value,
    output logic signed [7:0] o_lr_offset,
    output logic signed [7:0] o_fb_offset
);

    logic          accept;
    logic          fr_op_push;
    sfd_pkg::t_op  fr_op;
    logic          opq_empty;
    sfd_pkg::t_op  opq_op;
    logic          bk_op_pop;
    logic          resq_full;
    logic          bk_res_push;
    sfd_pkg::t_res bk_res;
    sfd_pkg::t_res resq_head;

    // A byte is taken whenever the item queue between the two halves has room.
    assign accept = push && !full;

    // The front end sees every byte, tracks the previous-byte-was-FF flag and
    // whether a frame is open, and forwards header, body and trailer items.
    sfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_rx_byte),
        .o_op_push (fr_op_push),
        .o_op      (fr_op)
    );

    // Short queue that lets the front end keep taking bytes while the back end
    // waits for room to report a status.
    sfd_fifo #(
        .WIDTH ($bits(sfd_pkg::t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_op_push),
        .i_data  (fr_op),
        .o_full  (full),
        .i_pop   (bk_op_pop),
        .o_empty (opq_empty),
        .o_data  (opq_op)
    );

    // The back end delays body bytes by two so that the checksum byte is known
    // at the trailer, unstuffs escapes, sums, counts and checks each frame.
    sfd_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!opq_empty),
        .i_op       (opq_op),
        .o_op_pop   (bk_op_pop),
        .i_res_full (resq_full),
        .o_res_push (bk_res_push),
        .o_res      (bk_res)
    );

    // Result queue: the oldest status waits here until the consumer pops it,
    // while the back end goes on with the next frame.
    sfd_fifo #(
        .WIDTH ($bits(sfd_pkg::t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_res_push),
        .i_data  (bk_res),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (resq_head)
    );

    assign o_frame_status = resq_head.status;
    assign o_mode_value   = resq_head.mode;
    assign o_lr_offset    = resq_head.lr;
    assign o_fb_offset    = resq_head.fb;

endmodule
